>>> hw/rtl/sender_congestion_window_control_core_macros.svh
// Assertion macros shared by the congestion window control checker.
`ifndef SENDER_CONGESTION_WINDOW_CONTROL_CORE_MACROS_SVH
`define SENDER_CONGESTION_WINDOW_CONTROL_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SCWC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SCWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/scwc_pkg.sv
// Package: types and constants of the congestion window control block.
`timescale 1ns / 1ps
package scwc_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PREP,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // Configuration register indexes
  localparam logic [2:0] REG_MAX_WINDOW   = 3'd0;
  localparam logic [2:0] REG_INIT_THRESH  = 3'd1;
  localparam logic [2:0] REG_DUP_LIMIT    = 3'd2;
  localparam logic [2:0] REG_SEGMENT      = 3'd3;
  localparam logic [2:0] REG_TRANSFER     = 3'd4;

  // Reset values of the configuration registers
  localparam logic [7:0]  RST_MAX_WINDOW  = 8'd100;
  localparam logic [7:0]  RST_INIT_THRESH = 8'd100;
  localparam logic [2:0]  RST_DUP_LIMIT   = 3'd3;
  localparam logic [15:0] RST_SEGMENT     = 16'd1456;
  localparam logic [31:0] RST_TRANSFER    = 32'd0;

  // Event codes
  localparam logic ACT_ACK     = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;

  // Duplicate counter ceiling and loss threshold floor and ceiling
  localparam logic [2:0] DUP_MAX    = 3'd7;
  localparam logic [7:0] THRESH_MIN = 8'd2;
  localparam logic [7:0] THRESH_MAX = 8'd255;

  // Divider geometry
  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 16;

endpackage

>>> hw/rtl/sender_congestion_window_control_core.sv
// Top level: sender window control with Tahoe-style congestion control.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+---------------------------------------------
//   event in | in_valid/in_ready  | action, ack_number
//   result   | out_valid/out_ready| send_seq, send_count, retransmit,
//            |                    | window_now, stale_ack, finished
//   config   | cfg_write          | cfg_index, cfg_data (write only)
//
// Each event passes the update, prep and finish states; when packets are left
// to count it also passes the divide state, where the one-bit-a-cycle divider
// turns remaining bytes into remaining packets; other events skip the divider.
// in_ready is high only in the idle state; one event is worked at a time.
// A finished result sits in the output register while the next event is
// taken; the sequencer holds in its last state if that register is still full.
// rst is synchronous and restores all configuration and window state.
`timescale 1ns / 1ps
module sender_congestion_window_control_core #(
  parameter int WINDOW_CAP = 128
) (
  input  logic        clk,
  input  logic        rst,
  // event channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] ack_number,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] send_seq,
  output logic [7:0]  send_count,
  output logic        retransmit,
  output logic [7:0]  window_now,
  output logic        stale_ack,
  output logic        finished,
  // configuration port
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Window width follows the cap; compares run at least at threshold width.
  localparam int CW_W  = $clog2(WINDOW_CAP + 1);
  localparam int CMP_W = (CW_W > 8) ? CW_W : 8;
  localparam logic [CW_W:0]    CAP_X = (CW_W + 1)'(WINDOW_CAP);
  localparam logic [CW_W-1:0]  CW_ONE = CW_W'(1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [7:0]  max_window;
  logic [2:0]  dup_ack_limit;
  logic [15:0] segment_bytes;
  logic [31:0] transfer_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_window     <= scwc_pkg::RST_MAX_WINDOW;
      dup_ack_limit  <= scwc_pkg::RST_DUP_LIMIT;
      segment_bytes  <= scwc_pkg::RST_SEGMENT;
      transfer_bytes <= scwc_pkg::RST_TRANSFER;
    end else if (cfg_write) begin
      case (cfg_index)
        scwc_pkg::REG_MAX_WINDOW: max_window     <= cfg_data[7:0];
        scwc_pkg::REG_DUP_LIMIT:  dup_ack_limit  <= cfg_data[2:0];
        scwc_pkg::REG_SEGMENT:    segment_bytes  <= cfg_data[15:0];
        scwc_pkg::REG_TRANSFER:   transfer_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  scwc_pkg::state_t state, state_next;

  logic in_xfer;
  logic out_free;
  logic upd_en;
  logic div_start;
  logic prep_no_div;
  logic fin_load;
  logic div_done;

  // event registers
  logic        act_q;
  logic [31:0] ack_q;

  // window state
  logic [31:0]     acked_bytes;
  logic [CW_W-1:0] cong_window;
  logic [7:0]      slow_start_limit;
  logic            in_avoidance;
  logic [2:0]      dup_count;

  // step outcome
  logic send_q, loss_q, stale_q;

  assign in_ready = (state == scwc_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scwc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    upd_en      = 1'b0;
    div_start   = 1'b0;
    prep_no_div = 1'b0;
    fin_load    = 1'b0;
    case (state)
      scwc_pkg::ST_IDLE: begin
        if (in_xfer) state_next = scwc_pkg::ST_UPDATE;
      end
      scwc_pkg::ST_UPDATE: begin
        upd_en     = 1'b1;
        state_next = scwc_pkg::ST_PREP;
      end
      scwc_pkg::ST_PREP: begin
        // count remaining packets only when something is sent and bytes remain
        if (send_q && (acked_bytes < transfer_bytes)) begin
          div_start  = 1'b1;
          state_next = scwc_pkg::ST_DIVIDE;
        end else begin
          prep_no_div = 1'b1;
          state_next  = scwc_pkg::ST_FINISH;
        end
      end
      scwc_pkg::ST_DIVIDE: begin
        if (div_done) state_next = scwc_pkg::ST_FINISH;
      end
      scwc_pkg::ST_FINISH: begin
        if (out_free) begin
          fin_load   = 1'b1;
          state_next = scwc_pkg::ST_IDLE;
        end
      end
      default: state_next = scwc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_q <= action;
      ack_q <= ack_number;
    end
  end

  // ---------------------------------------------------------------------
  // Window update for one event
  // ---------------------------------------------------------------------
  logic [31:0]     ack_sat;
  logic [2:0]      dup_limit_eff;
  logic [2:0]      dup_inc;
  logic [CW_W:0]   cw_dbl;
  logic [CW_W:0]   cw_inc;
  logic [CW_W-1:0] cw_grow;
  logic            avoid_grow;
  logic [CMP_W-1:0] half_x;
  logic [7:0]      ssl_loss;

  logic [31:0]     acked_next;
  logic [CW_W-1:0] cw_next;
  logic [7:0]      ssl_next;
  logic            avoid_next;
  logic [2:0]      dup_next;
  logic            send_next, loss_next, stale_next;

  always_comb begin
    ack_sat       = (ack_q > transfer_bytes) ? transfer_bytes : ack_q;
    dup_limit_eff = (dup_ack_limit == 3'd0) ? 3'd1 : dup_ack_limit;
    dup_inc       = (dup_count < scwc_pkg::DUP_MAX) ? dup_count + 3'd1 : dup_count;

    // growth: double in slow start, add one in avoidance, both capped
    cw_dbl = {cong_window, 1'b0};
    cw_inc = {1'b0, cong_window} + (CW_W + 1)'(1);
    if (!in_avoidance) begin
      cw_grow    = (cw_dbl > CAP_X) ? CAP_X[CW_W-1:0] : cw_dbl[CW_W-1:0];
      avoid_grow = CMP_W'(cw_grow) >= CMP_W'(slow_start_limit);
    end else begin
      cw_grow    = (cw_inc > CAP_X) ? CAP_X[CW_W-1:0] : cw_inc[CW_W-1:0];
      avoid_grow = 1'b1;
    end

    // loss threshold: half the old window, clamped to [2, 255]
    half_x = CMP_W'(cong_window >> 1);
    if (half_x < CMP_W'(scwc_pkg::THRESH_MIN)) begin
      ssl_loss = scwc_pkg::THRESH_MIN;
    end else if (half_x > CMP_W'(scwc_pkg::THRESH_MAX)) begin
      ssl_loss = scwc_pkg::THRESH_MAX;
    end else begin
      ssl_loss = half_x[7:0];
    end

    acked_next = acked_bytes;
    cw_next    = cong_window;
    ssl_next   = slow_start_limit;
    avoid_next = in_avoidance;
    dup_next   = dup_count;
    send_next  = 1'b0;
    loss_next  = 1'b0;
    stale_next = 1'b0;

    if (act_q == scwc_pkg::ACT_TIMEOUT) begin
      loss_next = 1'b1;
    end else if (ack_sat < acked_bytes) begin
      stale_next = 1'b1;
    end else if (ack_sat == acked_bytes) begin
      dup_next = dup_inc;
      if (dup_inc >= dup_limit_eff) loss_next = 1'b1;
    end else begin
      acked_next = ack_sat;
      dup_next   = 3'd0;
      cw_next    = cw_grow;
      avoid_next = avoid_grow;
      send_next  = 1'b1;
    end

    if (loss_next) begin
      ssl_next   = ssl_loss;
      cw_next    = CW_ONE;
      avoid_next = 1'b0;
      dup_next   = 3'd0;
      send_next  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acked_bytes      <= '0;
      cong_window      <= CW_ONE;
      slow_start_limit <= scwc_pkg::RST_INIT_THRESH;
      in_avoidance     <= 1'b0;
      dup_count        <= '0;
    end else if (cfg_write && cfg_index == scwc_pkg::REG_INIT_THRESH) begin
      // loading the initial threshold loads the live threshold; no separate copy is kept
      slow_start_limit <= cfg_data[7:0];
    end else if (upd_en) begin
      acked_bytes      <= acked_next;
      cong_window      <= cw_next;
      slow_start_limit <= ssl_next;
      in_avoidance     <= avoid_next;
      dup_count        <= dup_next;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      send_q  <= send_next;
      loss_q  <= loss_next;
      stale_q <= stale_next;
    end
  end

  // ---------------------------------------------------------------------
  // Packets left: ceil((transfer - acked) / segment) on the serial divider
  // ---------------------------------------------------------------------
  logic [31:0] div_quo;
  logic        div_rem_nz;
  logic [32:0] left_q;

  scwc_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend    (transfer_bytes - acked_bytes),
    .divisor     (segment_bytes),
    .done        (div_done),
    .quotient    (div_quo),
    .rem_nonzero (div_rem_nz)
  );

  always_ff @(posedge clk) begin
    if (prep_no_div) begin
      left_q <= '0;
    end else if (div_done) begin
      left_q <= {1'b0, div_quo} + 33'(div_rem_nz);
    end
  end

  // ---------------------------------------------------------------------
  // Result: count = min(window, packets left, max_window)
  // ---------------------------------------------------------------------
  logic [CMP_W-1:0] win_lim;
  logic [32:0]      count_x;

  always_comb begin
    win_lim = (CMP_W'(cong_window) < CMP_W'(max_window)) ? CMP_W'(cong_window)
                                                          : CMP_W'(max_window);
    count_x = (33'(win_lim) > left_q) ? left_q : 33'(win_lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      send_seq   <= acked_bytes;
      send_count <= send_q ? count_x[7:0] : 8'd0;
      retransmit <= loss_q;
      window_now <= 8'(cong_window);
      stale_ack  <= stale_q;
      finished   <= acked_bytes >= transfer_bytes;
    end
  end

endmodule

>>> hw/rtl/scwc_div.sv
// Radix-2 restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module scwc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [scwc_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [scwc_pkg::DIVISOR_W-1:0]   divisor,
  output logic                             done,
  output logic [scwc_pkg::DIVIDEND_W-1:0]  quotient,
  output logic                             rem_nonzero
);

  localparam int DW = scwc_pkg::DIVIDEND_W;
  localparam int SW = scwc_pkg::DIVISOR_W;
  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] LAST_STEP = CW'(DW - 1);

  logic          active;
  logic [CW-1:0] step;
  logic [SW:0]   rem;
  logic [DW-1:0] quo;
  logic [SW-1:0] dsr;

  logic [SW:0]   shifted;
  logic          fits;
  logic [SW:0]   rem_next;

  always_comb begin
    shifted  = {rem[SW-1:0], quo[DW-1]};
    fits     = shifted >= {1'b0, dsr};
    rem_next = fits ? (shifted - {1'b0, dsr}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && step == LAST_STEP) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step <= '0;
      rem  <= '0;
      quo  <= dividend;
      // a zero divisor acts as one
      dsr  <= (divisor == '0) ? SW'(1) : divisor;
    end else if (active) begin
      step <= step + CW'(1);
      rem  <= rem_next;
      quo  <= {quo[DW-2:0], fits};
    end
  end

  assign quotient    = quo;
  assign rem_nonzero = |rem;

endmodule

>>> hw/rtl/scwc_checker.sv
// Port-level checker for the congestion window control block, with its bind.
`timescale 1ns / 1ps
`include "sender_congestion_window_control_core_macros.svh"
module scwc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] send_seq,
  input logic [7:0]  send_count,
  input logic        retransmit,
  input logic [7:0]  window_now,
  input logic        stale_ack,
  input logic        finished
);

  // a stalled result holds its base
  `SCWC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(send_seq), "result dropped or changed while stalled")

  // one event at a time: busy right after a transfer in
  `SCWC_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "event taken while another is in work")

  // an ignored acknowledgement sends nothing and is no loss
  `SCWC_ASSERT_NOW(a_stale_quiet, out_valid && stale_ack, send_count == 8'd0 && !retransmit, "stale acknowledgement caused a send")

  // loss always restarts the window at one packet
  `SCWC_ASSERT_NOW(a_loss_window, out_valid && retransmit, window_now == 8'd1, "window not reset on loss")

  // nothing is left to send once the transfer is fully acknowledged
  `SCWC_ASSERT_NOW(a_done_no_send, out_valid && finished, send_count == 8'd0, "send after transfer finished")

endmodule

bind sender_congestion_window_control_core scwc_checker u_scwc_checker (.*);
